// File: src/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg
// Shared types and constants for the window median selector.
// ----------------------------------------------------------------------------
package wms_pkg;

   // Largest window: 7 x 7 samples
   localparam int MAX_WINDOW = 49;
   localparam int IDX_W      = $clog2(MAX_WINDOW);   // store address width
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1); // counts up to the window size
   localparam int RAD_W      = 2;
   localparam int SAMPLE_W   = 8;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   // Register index, taken from paddr[2]
   localparam logic REG_RADIUS_X = 1'b0;
   localparam logic REG_RADIUS_Y = 1'b1;

   localparam logic [RAD_W-1:0]    RADIUS_RESET = RAD_W'(1);
   localparam logic [SAMPLE_W-1:0] NO_MEDIAN    = SAMPLE_W'(255);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_HOLD,
      ST_SWEEP,
      ST_JUDGE
   } state_type;

   // Window size (2*rx+1)*(2*ry+1)
   function automatic logic [CNT_W-1:0] window_size(input logic [RAD_W-1:0] rx,
                                                    input logic [RAD_W-1:0] ry);
      logic [CNT_W-1:0] wx;
      logic [CNT_W-1:0] wy;
      logic [2*CNT_W-1:0] prod;
      wx   = CNT_W'({rx, 1'b1});
      wy   = CNT_W'({ry, 1'b1});
      prod = wx * wy;
      return prod[CNT_W-1:0];
   endfunction

endpackage

// File: src/window_median_select.sv
// ----------------------------------------------------------------------------
// window_median_select
// Median of one 2-D window of 8-bit samples, one shared compare unit.
// ----------------------------------------------------------------------------
// Feed the samples of one (2*radius_x+1) x (2*radius_y+1) window in raster
// order, one item per start pulse. Every sample but the last of a window is
// taken while busy stays low. The last sample starts the median search: one
// 8-bit compare unit and one read port of the sample store go through every
// pair of samples, candidate by candidate, while busy stays high. The result
// shows on rsp_median_value for exactly one cycle with rsp_valid high, in the
// cycle busy drops; the receiver cannot stall it, so capture it then. Write
// the radius registers only while no window is in flight; a change between
// the samples of a window keeps the samples already held and takes the new
// size from the next sample on.
// ----------------------------------------------------------------------------
module window_median_select (
   input  logic                            clock,
   input  logic                            reset,
   // item channel
   input  logic                            start,
   output logic                            busy,
   input  logic [wms_pkg::SAMPLE_W-1:0]    req_sample,
   // result channel
   output logic                            rsp_valid,
   output logic [wms_pkg::SAMPLE_W-1:0]    rsp_median_value,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [wms_pkg::PADDR_W-1:0]     paddr,
   input  logic [wms_pkg::PDATA_W-1:0]     pwdata,
   output logic [wms_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);

   localparam int IDX_W = wms_pkg::IDX_W;
   localparam int CNT_W = wms_pkg::CNT_W;
   localparam int RAD_W = wms_pkg::RAD_W;
   localparam int SW    = wms_pkg::SAMPLE_W;

   // Sample store
   logic [SW-1:0] store [wms_pkg::MAX_WINDOW];

   wms_pkg::state_type state_ff, state_in;

   logic [RAD_W-1:0] radius_x_ff, radius_y_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] size_ff, size_in;     // window size latched for the search
   logic [CNT_W-1:0] cand_idx_ff, cand_idx_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] best_cnt_ff, best_cnt_in;
   logic [SW-1:0]    cand_ff, cand_in;
   logic [SW-1:0]    best_ff, best_in;
   logic [SW-1:0]    rd_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]    rsp_value_ff, rsp_value_in;

   logic             accept;
   logic [CNT_W-1:0] cur_size;
   logic [CNT_W-1:0] wr_idx;
   logic             last_sample;
   logic             rd_en;
   logic [CNT_W-1:0] rd_idx;
   logic             qualify;
   logic [CNT_W-1:0] half;
   logic             csr_write;

   // ------------------------------------------------------------------------
   // Register port: no wait states, registers picked by paddr[2]
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_x_ff <= wms_pkg::RADIUS_RESET;
         radius_y_ff <= wms_pkg::RADIUS_RESET;
      end else if (csr_write) begin
         if (paddr[2] == wms_pkg::REG_RADIUS_X) begin
            radius_x_ff <= pwdata[RAD_W-1:0];
         end else begin
            radius_y_ff <= pwdata[RAD_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == wms_pkg::REG_RADIUS_X) begin
         prdata[RAD_W-1:0] = radius_x_ff;
      end else begin
         prdata[RAD_W-1:0] = radius_y_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Fill side
   // ------------------------------------------------------------------------
   assign busy     = (state_ff != wms_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign cur_size = wms_pkg::window_size(radius_x_ff, radius_y_ff);

   // Saturate the write slot at the last entry of the store
   assign wr_idx = (fill_ff >= CNT_W'(wms_pkg::MAX_WINDOW - 1)) ?
                   CNT_W'(wms_pkg::MAX_WINDOW - 1) : fill_ff;
   assign last_sample = ({1'b0, wr_idx} + (CNT_W+1)'(1)) >= {1'b0, cur_size};

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (accept) begin
         store[wr_idx[IDX_W-1:0]] <= req_sample;
      end
      if (rd_en) begin
         rd_data_ff <= store[rd_idx[IDX_W-1:0]];
      end
   end

   // ------------------------------------------------------------------------
   // Search sequencer: for each candidate, sweep the window counting the
   // samples at or below it, then keep the candidate with the smallest count
   // above half the window.
   // ------------------------------------------------------------------------
   assign half    = size_ff >> 1;
   assign qualify = (cnt_ff > half) && (cnt_ff <= best_cnt_ff);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      size_in      = size_ff;
      cand_idx_in  = cand_idx_ff;
      scan_idx_in  = scan_idx_ff;
      cnt_in       = cnt_ff;
      best_cnt_in  = best_cnt_ff;
      cand_in      = cand_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rd_en        = 1'b0;
      rd_idx       = cand_idx_ff;

      case (state_ff)
         wms_pkg::ST_IDLE: begin
            if (accept) begin
               if (last_sample) begin
                  // Window complete: clear the fill count and start the search
                  fill_in     = '0;
                  size_in     = cur_size;
                  cand_idx_in = '0;
                  best_cnt_in = cur_size;
                  best_in     = wms_pkg::NO_MEDIAN;
                  state_in    = wms_pkg::ST_CAND;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end

         wms_pkg::ST_CAND: begin
            // Fetch the candidate
            rd_en    = 1'b1;
            rd_idx   = cand_idx_ff;
            state_in = wms_pkg::ST_HOLD;
         end

         wms_pkg::ST_HOLD: begin
            // Hold the candidate, fetch the first sample of the sweep
            cand_in     = rd_data_ff;
            rd_en       = 1'b1;
            rd_idx      = '0;
            scan_idx_in = CNT_W'(1);
            cnt_in      = '0;
            state_in    = wms_pkg::ST_SWEEP;
         end

         wms_pkg::ST_SWEEP: begin
            // rd_data_ff holds the sample fetched in the previous cycle
            if (rd_data_ff <= cand_ff) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (scan_idx_ff == size_ff) begin
               state_in = wms_pkg::ST_JUDGE;
            end else begin
               rd_en       = 1'b1;
               rd_idx      = scan_idx_ff;
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end

         wms_pkg::ST_JUDGE: begin
            if (qualify) begin
               best_in     = cand_ff;
               best_cnt_in = cnt_ff;
            end
            if (cand_idx_ff == size_ff - CNT_W'(1)) begin
               // Emit the result for exactly one cycle
               rsp_valid_in = 1'b1;
               rsp_value_in = qualify ? cand_ff : best_ff;
               state_in     = wms_pkg::ST_IDLE;
            end else begin
               cand_idx_in = cand_idx_ff + CNT_W'(1);
               state_in    = wms_pkg::ST_CAND;
            end
         end

         default: begin
            state_in = wms_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wms_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      size_ff      <= size_in;
      cand_idx_ff  <= cand_idx_in;
      scan_idx_ff  <= scan_idx_in;
      cnt_ff       <= cnt_in;
      best_cnt_ff  <= best_cnt_in;
      cand_ff      <= cand_in;
      best_ff      <= best_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_value_ff;

endmodule

// File: dv/window_median_select_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_median_select_tb
// Self-checking bench for the window median selector.
// ----------------------------------------------------------------------------
// Streams sample windows through the item channel at several radius settings.
// Prediction uses a cumulative histogram over the samples held for the
// window. It covers radius writes between windows and in the middle of one,
// read-back of the radius registers, and bursty and gap-heavy sender traffic.
// ----------------------------------------------------------------------------
module window_median_select_tb;

   localparam int SAMPLE_W   = wms_pkg::SAMPLE_W;
   localparam int RAD_W      = wms_pkg::RAD_W;
   localparam int PADDR_W    = wms_pkg::PADDR_W;
   localparam int PDATA_W    = wms_pkg::PDATA_W;
   localparam int MAX_WINDOW = wms_pkg::MAX_WINDOW;

   localparam int unsigned CLOCK_HALF   = 10;
   localparam int unsigned LONGEST_RUN  = 2600;      // 7x7 search plus margin
   localparam int unsigned TIMEOUT_CYC  = 1_000_000;
   localparam int unsigned SAMPLE_GOAL  = 1550;

   typedef enum {
      FILL_RANDOM,
      FILL_NARROW,
      FILL_FLAT,
      FILL_RISING,
      FILL_FALLING,
      FILL_EXTREME
   } fill_style_type;

   // DUT connections; every input starts at a known value
   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic [SAMPLE_W-1:0]   req_sample       = '0;
   logic                  rsp_valid;
   logic [SAMPLE_W-1:0]   rsp_median_value;
   logic                  psel             = 1'b0;
   logic                  penable          = 1'b0;
   logic                  pwrite           = 1'b0;
   logic [PADDR_W-1:0]    paddr            = '0;
   logic [PDATA_W-1:0]    pwdata           = '0;
   logic [PDATA_W-1:0]    prdata;
   logic                  pready;

   // Sender traffic and scoreboard
   logic [SAMPLE_W-1:0]   pending_samples [$];
   logic [SAMPLE_W-1:0]   expected_medians [$];
   int unsigned           sender_idle_pct  = 0;
   int unsigned           error_count      = 0;
   int unsigned           samples_sent     = 0;
   int unsigned           medians_checked  = 0;

   // Predictor state: its own copy of the radii and the sample store
   logic [RAD_W-1:0]      model_rx         = wms_pkg::RADIUS_RESET;
   logic [RAD_W-1:0]      model_ry         = wms_pkg::RADIUS_RESET;
   logic [SAMPLE_W-1:0]   held_samples [MAX_WINDOW];
   int unsigned           held_count       = 0;

   window_median_select dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_median_value (rsp_median_value),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   // Window size from the predictor's radii
   function automatic int unsigned span_of(input logic [RAD_W-1:0] rx,
                                           input logic [RAD_W-1:0] ry);
      return (2 * int'(rx) + 1) * (2 * int'(ry) + 1);
   endfunction

   // Median as the smallest value whose cumulative count passes half the window
   function automatic logic [SAMPLE_W-1:0] median_of_held(input int unsigned n);
      int unsigned hist [256];
      int unsigned running;
      for (int v = 0; v < 256; v++) hist[v] = 0;
      for (int unsigned i = 0; i < n; i++) hist[held_samples[i]]++;
      running = 0;
      for (int v = 0; v < 256; v++) begin
         running += hist[v];
         if (running > n / 2) return SAMPLE_W'(v);
      end
      return wms_pkg::NO_MEDIAN;
   endfunction

   // Take one accepted sample into the store; queue a median once the window fills
   function automatic void absorb_sample(input logic [SAMPLE_W-1:0] value);
      int unsigned n;
      int unsigned slot;
      n    = span_of(model_rx, model_ry);
      slot = (held_count >= MAX_WINDOW) ? MAX_WINDOW - 1 : held_count;
      held_samples[slot] = value;
      held_count = (held_count + 1) & 63;
      // a window shrunk mid-fill completes on the next sample and judges
      // only its first n entries
      if (held_count >= n || slot + 1 >= n) begin
         expected_medians.push_back(median_of_held(n));
         held_count = 0;
      end
   endfunction

   // Queue `count` samples whose content follows the given style
   function automatic void queue_samples(input int unsigned    count,
                                         input fill_style_type style);
      logic [SAMPLE_W-1:0] base;
      logic [SAMPLE_W-1:0] value;
      int unsigned         steps;
      base  = SAMPLE_W'($urandom_range(255));
      steps = (count > 1) ? count - 1 : 1;
      for (int unsigned i = 0; i < count; i++) begin
         case (style)
            FILL_NARROW:  value = base ^ SAMPLE_W'($urandom_range(3));
            FILL_FLAT:    value = base;
            FILL_RISING:  value = SAMPLE_W'((i * 255) / steps);
            FILL_FALLING: value = SAMPLE_W'(255 - (i * 255) / steps);
            FILL_EXTREME: value = $urandom_range(1) ? 8'hFF : 8'h00;
            default:      value = SAMPLE_W'($urandom_range(255));
         endcase
         pending_samples.push_back(value);
      end
   endfunction

   // Pick a window style: half full-range random content, the rest shaped
   function automatic fill_style_type pick_style();
      case ($urandom_range(9))
         5:       return FILL_NARROW;
         6:       return FILL_FLAT;
         7:       return FILL_RISING;
         8:       return FILL_FALLING;
         9:       return FILL_EXTREME;
         default: return FILL_RANDOM;
      endcase
   endfunction

   // Read one radius register and compare it with the predictor's copy
   task automatic read_radius(input logic reg_sel, input logic [RAD_W-1:0] want);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== PDATA_W'(want)) begin
         $error("radius register %0d: expected %0d, got %0d", reg_sel, want, prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write one radius register (junk in the upper data bits), then read it back
   task automatic write_radius(input logic reg_sel, input logic [RAD_W-1:0] value);
      logic [PDATA_W-1:0] word;
      word = $urandom();
      word[RAD_W-1:0] = value;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      // the register takes the value at this edge
      if (reg_sel == wms_pkg::REG_RADIUS_X) model_rx = value;
      else                                  model_ry = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      read_radius(reg_sel, value);
   endtask

   // Hold until every queued sample is taken, the search is over and every
   // predicted median has come back; check at the falling edge to stay clear
   // of the driver and the monitor
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (pending_samples.size() != 0 || start || busy || expected_medians.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Driver: present the oldest pending sample; hold it while busy is high,
   // advance on acceptance, and drop start on a random idle cycle
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            absorb_sample(req_sample);
            void'(pending_samples.pop_front());
            samples_sent++;
         end
         if (!start || !busy) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               start      <= 1'b1;
               req_sample <= pending_samples[0];
            end else begin
               start      <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: a median is on the port for one cycle only; take it at the edge
   // that ends that cycle and compare it with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid) begin
         if (expected_medians.size() == 0) begin
            $error("median_value: no median expected, got %0d", rsp_median_value);
            error_count++;
         end else begin
            want = expected_medians.pop_front();
            medians_checked++;
            if (rsp_median_value !== want) begin
               $error("median_value: expected %0d, got %0d", want, rsp_median_value);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [SAMPLE_W-1:0] opening [9];
      logic [RAD_W-1:0]    set_rx [6];
      logic [RAD_W-1:0]    set_ry [6];
      int unsigned         idle_plan [3];
      int unsigned         phase;
      int unsigned         n;
      int unsigned         windows;
      int unsigned         random_start;

      opening   = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd1, 8'd254, 8'd85, 8'd170, 8'd0};
      set_rx    = '{2'd0, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1};
      set_ry    = '{2'd0, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2};
      idle_plan = '{0, 71, 9};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values read back; first window at the reset size of 3x3,
      // with both sample extremes, alternating bit patterns and a tie
      read_radius(wms_pkg::REG_RADIUS_X, wms_pkg::RADIUS_RESET);
      read_radius(wms_pkg::REG_RADIUS_Y, wms_pkg::RADIUS_RESET);
      foreach (opening[i]) pending_samples.push_back(opening[i]);
      wait_for_quiet();

      // Smallest window: every sample is its own median
      write_radius(wms_pkg::REG_RADIUS_X, 2'd0);
      write_radius(wms_pkg::REG_RADIUS_Y, 2'd0);
      pending_samples.push_back(8'd0);
      pending_samples.push_back(8'd255);
      wait_for_quiet();

      // Three-wide row of equal samples: all counts tie
      write_radius(wms_pkg::REG_RADIUS_X, 2'd1);
      queue_samples(3, FILL_FLAT);
      wait_for_quiet();

      // Shrink the window mid-fill: five samples held, new size 1, so the
      // next sample closes the window and only the first held one is judged
      write_radius(wms_pkg::REG_RADIUS_Y, 2'd1);
      queue_samples(5, FILL_RANDOM);
      wait_for_quiet();
      write_radius(wms_pkg::REG_RADIUS_X, 2'd0);
      write_radius(wms_pkg::REG_RADIUS_Y, 2'd0);
      queue_samples(1, FILL_RANDOM);
      wait_for_quiet();

      // Random part: one radius setting per phase, extremes first. A phase
      // may end on a partial window, so the next write lands mid-window.
      random_start = samples_sent;
      phase = 0;
      while (samples_sent - random_start < SAMPLE_GOAL) begin
         if (phase < 6) begin
            write_radius(wms_pkg::REG_RADIUS_X, set_rx[phase]);
            write_radius(wms_pkg::REG_RADIUS_Y, set_ry[phase]);
         end else begin
            write_radius(wms_pkg::REG_RADIUS_X, RAD_W'($urandom_range(3)));
            write_radius(wms_pkg::REG_RADIUS_Y, RAD_W'($urandom_range(3)));
         end
         sender_idle_pct = idle_plan[phase % 3];
         n = span_of(model_rx, model_ry);
         windows = (n >= 108) ? 1 : 108 / n;
         for (int unsigned w = 0; w < windows; w++) queue_samples(n, pick_style());
         if (n > 1 && $urandom_range(1)) queue_samples($urandom_range(n - 1, 1), pick_style());
         wait_for_quiet();
         phase++;
      end

      // Any stray median would show within one full 7x7 search
      sender_idle_pct = 0;
      repeat (LONGEST_RUN) @(negedge clock);
      if (expected_medians.size() != 0) begin
         $error("median_value: %0d predicted medians never arrived", expected_medians.size());
         error_count++;
      end

      $display("Covered %0d samples and %0d medians over %0d random radius settings,",
               samples_sent, medians_checked, phase);
      $display("with mid-window radius changes and sender gaps of 0, 9 and 71 percent.");
      if (error_count == 0) begin
         $display("window_median_select regression: pass");
      end else begin
         $display("window_median_select regression: fail");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here
   initial begin : watchdog
      #(TIMEOUT_CYC * 2 * CLOCK_HALF);
      $display("window_median_select regression: fail");
      $finish;
   end

endmodule
